[design/x2nv_pkg.sv]
package x2nv_pkg;

	// Line store operation attached to each pixel by the front end.
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [12:0] WIDTH_RESET  = 13'd1920;
	localparam logic [12:0] HEIGHT_RESET = 13'd1080;
	localparam logic [12:0] HEIGHT_CAP   = 13'd4096;

	// One classified pixel as it travels from the front end to the back end.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] sum_r;
		logic [8:0] sum_g;
		logic [8:0] sum_b;
		logic [1:0] op;
		logic       eof;
	} item_t;

endpackage

[design/x2nv_front.sv]
module x2nv_front #(
	parameter int MAX_WIDTH = 4096,
	parameter int SLOT_W    = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [12:0]       frame_width,
	input  logic [12:0]       frame_height,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       pixel_word,
	input  logic              start_of_frame,
	input  logic              queue_full,
	output logic              push,
	output x2nv_pkg::item_t   item,
	output logic [SLOT_W-1:0] slot
);

	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [13:0] MAX_W14 = 14'(MAX_WIDTH);

	logic [COL_W-1:0] col_q;
	logic [11:0]      row_q;
	logic [23:0]      left_q;

	logic [COL_W-1:0] col_cur;
	logic [11:0]      row_cur;
	logic [13:0]      w_eff;
	logic [12:0]      h_eff;
	logic             last_col;
	logic             last_row;
	logic [7:0]       red;
	logic [7:0]       green;
	logic [7:0]       blue;

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	assign red   = pixel_word[23:16];
	assign green = pixel_word[15:8];
	assign blue  = pixel_word[7:0];

	always_comb begin
		if (frame_width == 13'd0) begin
			w_eff = 14'd1;
		end else if ({1'b0, frame_width} > MAX_W14) begin
			w_eff = MAX_W14;
		end else begin
			w_eff = {1'b0, frame_width};
		end
		if (frame_height == 13'd0) begin
			h_eff = 13'd1;
		end else if (frame_height > x2nv_pkg::HEIGHT_CAP) begin
			h_eff = x2nv_pkg::HEIGHT_CAP;
		end else begin
			h_eff = frame_height;
		end
	end

	assign col_cur  = start_of_frame ? '0 : col_q;
	assign row_cur  = start_of_frame ? '0 : row_q;
	assign last_col = (14'(col_cur) + 14'd1) >= w_eff;
	assign last_row = (13'(row_cur) + 13'd1) >= h_eff;

	always_comb begin
		item.red   = red;
		item.green = green;
		item.blue  = blue;
		item.sum_r = {1'b0, left_q[23:16]} + {1'b0, red};
		item.sum_g = {1'b0, left_q[15:8]} + {1'b0, green};
		item.sum_b = {1'b0, left_q[7:0]} + {1'b0, blue};
		item.eof   = last_col && last_row;
		if (!col_cur[0]) begin
			item.op = x2nv_pkg::OP_NONE;
		end else if (row_cur[0]) begin
			item.op = x2nv_pkg::OP_READ;
		end else begin
			item.op = x2nv_pkg::OP_WRITE;
		end
	end

	assign slot = SLOT_W'(col_cur >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (push) begin
			left_q <= pixel_word[23:0];
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 12'd0 : row_cur + 12'd1;
			end else begin
				col_q <= col_cur + COL_W'(1);
				row_q <= row_cur;
			end
		end
	end

endmodule

[design/x2nv_queue.sv]
module x2nv_queue #(
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output logic          full,
	output logic          nonempty
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	logic [DW-1:0] entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full     = count_q == (AW+1)'(DEPTH);
	assign nonempty = count_q != '0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

[design/x2nv_back.sv]
module x2nv_back #(
	parameter int SLOT_W = 11,
	parameter int DEPTH  = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  x2nv_pkg::item_t   item,
	input  logic [SLOT_W-1:0] slot,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [23:0]       out_data,
	output logic              out_chroma,
	output logic              out_last
);

	// Signed numerator divided by 256 toward zero, offset by 128, clamped to a byte.
	function automatic logic [7:0] to_byte(input logic signed [16:0] n);
		logic signed [16:0] q;
		logic signed [16:0] v;
		begin
			q = (n + ((n < 0) ? 17'sd255 : 17'sd0)) >>> 8;
			v = q + 17'sd128;
			if (v < 0) begin
				to_byte = 8'd0;
			end else if (v > 17'sd255) begin
				to_byte = 8'd255;
			end else begin
				to_byte = v[7:0];
			end
		end
	endfunction

	logic [26:0] store [DEPTH];

	logic        adv;
	logic [15:0] luma_sum;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [7:0]  luma_s1, luma_s2, luma_s3, luma_s4;
	logic        eof_s1, eof_s2, eof_s3, eof_s4;
	logic [1:0]  op_s1;
	logic [8:0]  sum_r_s1, sum_g_s1, sum_b_s1;
	logic [26:0] rdata_s1;
	logic        chroma_s2, chroma_s3, chroma_s4;
	logic [7:0]  avg_r_s2, avg_g_s2, avg_b_s2;
	logic signed [16:0] num_cb_s3, num_cr_s3;
	logic [7:0]  cb_s4, cr_s4;

	logic [9:0]  tot_r, tot_g, tot_b;
	logic signed [16:0] ar, ag, ab;

	// The whole pipeline moves together whenever the output register can take a beat.
	assign adv = !valid_s4 || out_ready;
	assign pop = adv && in_valid;

	assign luma_sum = 16'd77 * 16'(item.red) + 16'd150 * 16'(item.green)
		+ 16'd29 * 16'(item.blue);

	always_ff @(posedge clk) begin
		if (pop && item.op == x2nv_pkg::OP_WRITE) begin
			store[slot] <= {item.sum_r, item.sum_g, item.sum_b};
		end
		if (pop && item.op == x2nv_pkg::OP_READ) begin
			rdata_s1 <= store[slot];
		end
	end

	assign tot_r = 10'(sum_r_s1) + 10'(rdata_s1[26:18]);
	assign tot_g = 10'(sum_g_s1) + 10'(rdata_s1[17:9]);
	assign tot_b = 10'(sum_b_s1) + 10'(rdata_s1[8:0]);

	assign ar = 17'(avg_r_s2);
	assign ag = 17'(avg_g_s2);
	assign ab = 17'(avg_b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			luma_s1  <= luma_sum[15:8];
			eof_s1   <= item.eof;
			op_s1    <= item.op;
			sum_r_s1 <= item.sum_r;
			sum_g_s1 <= item.sum_g;
			sum_b_s1 <= item.sum_b;
		end
		if (adv) begin
			luma_s2   <= luma_s1;
			eof_s2    <= eof_s1;
			chroma_s2 <= valid_s1 && op_s1 == x2nv_pkg::OP_READ;
			avg_r_s2  <= tot_r[9:2];
			avg_g_s2  <= tot_g[9:2];
			avg_b_s2  <= tot_b[9:2];

			luma_s3   <= luma_s2;
			eof_s3    <= eof_s2;
			chroma_s3 <= chroma_s2;
			num_cb_s3 <= -17'sd43 * ar - 17'sd85 * ag + 17'sd128 * ab;
			num_cr_s3 <= 17'sd128 * ar - 17'sd107 * ag - 17'sd21 * ab;

			luma_s4   <= luma_s3;
			eof_s4    <= eof_s3;
			chroma_s4 <= chroma_s3;
			cb_s4     <= chroma_s3 ? to_byte(num_cb_s3) : 8'd0;
			cr_s4     <= chroma_s3 ? to_byte(num_cr_s3) : 8'd0;
		end
	end

	assign out_valid  = valid_s4;
	assign out_data   = {cr_s4, cb_s4, luma_s4};
	assign out_chroma = chroma_s4;
	assign out_last   = eof_s4;

endmodule

[design/xrgb_to_nv12_converter.sv]
// XRGB8888 to 4:2:0 YCbCr (BT.601 full range) stream converter.
//
// Pixels enter in raster order on the s_axis channel, one beat per pixel, with
// tuser set on the first pixel of a frame. Every input beat produces exactly one
// output beat on m_axis: luma for the pixel, plus Cb and Cr (flagged by tuser)
// when the pixel is the lower right corner of a 2x2 block. tlast marks the last
// pixel of the frame as set by the frame_width and frame_height registers, which
// the user writes via the cfg channel only while the stream is idle; not enforced.
//
// Throughput is one pixel per clock while the receiver takes each beat. A pixel
// passes through the four-entry queue behind the position tracker and then four
// pipeline stages (line store access and luma, block averages, chroma products,
// rounding and clamp into the output register). The line store holds one row
// of pair sums.
//
// Reset clears the row and column position, the queue and the pipeline; the
// registers return to 1920 by 1080. When the receiver stalls, the output beat
// holds, the pipeline freezes, and the queue keeps accepting pixels until its
// four entries are full, at which point s_axis_tready drops.
module xrgb_to_nv12_converter #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel input.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // pixel_word[31:0]
	input  logic        s_axis_tuser,   // start_of_frame
	// Result output.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // luma[7:0], blue_difference[15:8], red_difference[23:16]
	output logic        m_axis_tuser,   // chroma_valid
	output logic        m_axis_tlast,   // end_of_frame
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int DEPTH  = (MAX_WIDTH + 1) / 2;
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW     = SLOT_W + $bits(x2nv_pkg::item_t);

	logic [12:0] width_q;
	logic [12:0] height_q;

	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_nonempty;
	x2nv_pkg::item_t   front_item;
	logic [SLOT_W-1:0] front_slot;
	logic [QW-1:0]     q_head;
	x2nv_pkg::item_t   back_item;
	logic [SLOT_W-1:0] back_slot;

	// Configuration registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= x2nv_pkg::WIDTH_RESET;
			height_q <= x2nv_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				x2nv_pkg::CFG_FRAME_WIDTH: begin
					width_q <= cfg_data;
				end
				x2nv_pkg::CFG_FRAME_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	// The front end tracks the raster position and tags each pixel with its line
	// store operation, so the back end never needs to know where it is in the frame.
	x2nv_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.SLOT_W    (SLOT_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_width    (width_q),
		.frame_height   (height_q),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.pixel_word     (s_axis_tdata),
		.start_of_frame (s_axis_tuser),
		.queue_full     (q_full),
		.push           (q_push),
		.item           (front_item),
		.slot           (front_slot)
	);

	x2nv_queue #(
		.DW (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({front_slot, front_item}),
		.pop       (q_pop),
		.pop_data  (q_head),
		.full      (q_full),
		.nonempty  (q_nonempty)
	);

	assign back_item = q_head[$bits(x2nv_pkg::item_t)-1:0];
	assign back_slot = q_head[QW-1:$bits(x2nv_pkg::item_t)];

	// The back end owns the line store and the arithmetic pipeline. Store writes
	// and reads happen in stream order, so a read always sees the row above.
	x2nv_back #(
		.SLOT_W (SLOT_W),
		.DEPTH  (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_nonempty),
		.item       (back_item),
		.slot       (back_slot),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_chroma (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

	// Luma-only beats carry zero chroma bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[23:8] == 16'd0))
		else $error("chroma bytes not zero on a luma-only beat");

	// A stalled output beat must freeze the back end.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !q_pop)
		else $error("queue popped while the output is stalled");

	// Popping without a push always leaves room in the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_push) |=> !q_full)
		else $error("queue full right after a pop");

endmodule
